>>> hdl/rbfor_pkg.sv
// Package for the ramped burst-fire oven regulator: field widths, codes, word layouts
// and the structs passed between the top level, the sequencer and the shared divider.
// No dependencies.
`timescale 1ns / 1ps

package rbfor_pkg;

    localparam int SENSOR_W    = 20;
    localparam int SUM_W       = 22;
    localparam int RATE_W      = 17;
    localparam int TOL_W       = 16;
    localparam int LIMIT_W     = 19;
    localparam int MS_W        = 16;
    localparam int MASK_W      = 3;
    localparam int BON_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 19;

    localparam int DIV_W       = 34;
    localparam int DVR_W       = 16;
    localparam int DIV_STEPS   = DIV_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    localparam int PWR_FULL_SCALE = 1000;
    localparam int MS_PER_S       = 1000;
    localparam int BURST_WINDOW   = 20;
    localparam int ROUND_HALF     = 500;
    localparam int BURST_MAX      = 31;
    localparam int PWR_Q_W        = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATER_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSORS_FIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OT_LIMIT    = 3'd4;

    localparam logic [RATE_W-1:0]  RST_RAMP_RATE   = 17'd0;
    localparam logic [TOL_W-1:0]   RST_TOLERANCE   = 16'd5000;
    localparam logic [MASK_W-1:0]  RST_HEATER_EN   = 3'd0;
    localparam logic [MASK_W-1:0]  RST_SENSORS_FIT = 3'd7;
    localparam logic [LIMIT_W-1:0] RST_OT_LIMIT    = 19'd280000;

    localparam logic [MASK_W-1:0]  ALL_HEATERS     = 3'd7;

    localparam int FL_ACTIVE   = 0;
    localparam int FL_ATTEMP   = 1;
    localparam int FL_OVERTEMP = 2;
    localparam int FL_FAULT    = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_OFF   = 2'd0,
        ACT_FULL  = 2'd1,
        ACT_BURST = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OVEN_IDLE    = 2'd0,
        OVEN_HEATING = 2'd1,
        OVEN_ATTEMP  = 2'd2,
        OVEN_COOLING = 2'd3
    } t_oven_state;

    typedef struct packed {
        logic [RATE_W-1:0]  ramp_rate;
        logic [TOL_W-1:0]   tolerance;
        logic [MASK_W-1:0]  heater_enable;
        logic [MASK_W-1:0]  sensors_fitted;
        logic [LIMIT_W-1:0] over_temp_limit;
    } t_cfg;

    typedef struct packed {
        t_opcode                    opcode;
        logic [MS_W-1:0]            elapsed_ms;
        logic signed [SENSOR_W-1:0] target_temp;
        logic signed [SENSOR_W-1:0] temp_sensor_a;
        logic signed [SENSOR_W-1:0] temp_sensor_b;
        logic signed [SENSOR_W-1:0] temp_sensor_c;
        logic [MASK_W-1:0]          sensor_fault;
        logic [MASK_W-1:0]          heater_fault;
    } t_item;

    typedef struct packed {
        t_action                    drive_action;
        logic [MASK_W-1:0]          drive_mask;
        logic [BON_W-1:0]           burst_on;
        logic signed [SENSOR_W-1:0] current_temp;
        t_oven_state                oven_state;
        logic [3:0]                 status_bits;
    } t_result;

    typedef struct packed {
        logic start;
        logic ack;
    } t_ctrl_cmd;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_ctrl_sts;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [DVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hdl/rbfor_div.sv
// Shared unsigned divider, two quotient bits per cycle, restoring.
// Depends on rbfor_pkg.
`timescale 1ns / 1ps

module rbfor_div
    import rbfor_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DVR_W-1:0]     r_rem;
    logic [DVR_W-1:0]     r_dvr;

    logic [DVR_W:0]   n_rem_a;
    logic [DVR_W:0]   n_rem_a2;
    logic [DVR_W:0]   n_rem_b;
    logic [DVR_W:0]   n_rem_b2;
    logic             n_ge_a;
    logic             n_ge_b;

    always_comb begin
        n_rem_a  = {r_rem, r_quo[DIV_W-1]};
        n_ge_a   = n_rem_a >= {1'b0, r_dvr};
        n_rem_a2 = n_ge_a ? n_rem_a - {1'b0, r_dvr} : n_rem_a;
        n_rem_b  = {n_rem_a2[DVR_W-1:0], r_quo[DIV_W-2]};
        n_ge_b   = n_rem_b >= {1'b0, r_dvr};
        n_rem_b2 = n_ge_b ? n_rem_b - {1'b0, r_dvr} : n_rem_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvr  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-3:0], n_ge_a, n_ge_b};
                r_rem <= n_rem_b2[DVR_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> hdl/rbfor_ctrl.sv
// Command sequencer of the oven regulator: ramp, averaging, limit checks and drive choice.
// Holds the ramp setpoint, status flags and oven state. Depends on rbfor_pkg and drives
// the shared divider rbfor_div.
`timescale 1ns / 1ps

module rbfor_ctrl
    import rbfor_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_ctrl_cmd i_cmd,
    input  t_item     i_item,
    input  t_div_rsp  i_div,
    output t_div_req  o_div,
    output t_ctrl_sts o_sts,
    output t_result   o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_RAMP_WAIT,
        S_AVG,
        S_AVG_WAIT,
        S_CHECK,
        S_PWR_WAIT,
        S_BURST_WAIT,
        S_FINISH
    } t_state;

    t_state                     r_state;
    t_item                      r_item;
    logic                       r_is_start;
    logic                       r_neg;
    logic signed [SENSOR_W-1:0] r_sp;
    logic signed [SENSOR_W-1:0] r_temp;
    logic [3:0]                 r_flags;
    t_oven_state                r_last;
    logic                       r_div_go;
    logic [DIV_W-1:0]           r_div_dividend;
    logic [DVR_W-1:0]           r_div_divisor;
    t_action                    r_res_act;
    logic [MASK_W-1:0]          r_res_mask;
    logic [BON_W-1:0]           r_res_bon;
    logic signed [SENSOR_W-1:0] r_res_temp;
    t_oven_state                r_res_st;

    logic [MASK_W-1:0]       n_vmask;
    logic signed [SUM_W-1:0] n_sa;
    logic signed [SUM_W-1:0] n_sb;
    logic signed [SUM_W-1:0] n_sc;
    logic signed [SUM_W-1:0] n_sum;
    logic [1:0]              n_cnt;
    logic [SUM_W-1:0]        n_sum_mag;
    logic [SENSOR_W:0]       n_avg_mag;
    logic [SENSOR_W:0]       n_avg;
    logic signed [SUM_W-1:0] n_target;
    logic signed [SUM_W-1:0] n_sp;
    logic signed [SUM_W-1:0] n_temp;
    logic signed [SUM_W-1:0] n_tol;
    logic signed [SUM_W-1:0] n_limit;
    logic signed [SUM_W-1:0] n_rem;
    logic signed [SUM_W-1:0] n_err;
    logic                    n_step_lt;
    logic signed [SUM_W-1:0] n_sp_next;
    logic [2*MS_W:0]         n_prod;
    logic [DIV_W-1:0]        n_pwr_dividend;
    logic [DIV_W-1:0]        n_burst_dividend;
    logic [BON_W-1:0]        n_bon;
    logic                    n_err_pos;

    always_comb begin
        n_vmask   = r_is_start ? i_cfg.sensors_fitted
                               : (i_cfg.sensors_fitted & ~r_item.sensor_fault);
        n_sa      = n_vmask[0] ? SUM_W'(r_item.temp_sensor_a) : '0;
        n_sb      = n_vmask[1] ? SUM_W'(r_item.temp_sensor_b) : '0;
        n_sc      = n_vmask[2] ? SUM_W'(r_item.temp_sensor_c) : '0;
        n_sum     = n_sa + n_sb + n_sc;
        n_cnt     = 2'(n_vmask[0]) + 2'(n_vmask[1]) + 2'(n_vmask[2]);
        n_sum_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);

        n_avg_mag = i_div.quotient[SENSOR_W:0];
        n_avg     = r_neg ? (SENSOR_W+1)'(-n_avg_mag) : n_avg_mag;

        n_target  = SUM_W'(r_item.target_temp);
        n_sp      = SUM_W'(r_sp);
        n_temp    = SUM_W'(r_temp);
        n_tol     = $signed({{(SUM_W-TOL_W){1'b0}}, i_cfg.tolerance});
        n_limit   = $signed({{(SUM_W-LIMIT_W){1'b0}}, i_cfg.over_temp_limit});

        n_rem     = n_target - n_sp;
        n_step_lt = i_div.quotient < DIV_W'($unsigned(n_rem));
        n_sp_next = n_sp + (n_step_lt ? $signed(i_div.quotient[SUM_W-1:0]) : n_rem);

        n_prod    = (2*MS_W+1)'(i_cfg.ramp_rate) * (2*MS_W+1)'(r_item.elapsed_ms);

        n_err     = n_target - n_temp;
        n_err_pos = !n_err[SUM_W-1] && (n_err != '0);
        n_pwr_dividend   = DIV_W'(n_err[TOL_W-1:0]) * DIV_W'(PWR_FULL_SCALE);
        n_burst_dividend = DIV_W'(i_div.quotient[PWR_Q_W-1:0]) * DIV_W'(BURST_WINDOW)
                         + DIV_W'(ROUND_HALF);

        if (i_div.quotient == '0) begin
            n_bon = BON_W'(1);
        end else if (i_div.quotient > DIV_W'(BURST_MAX)) begin
            n_bon = BON_W'(BURST_MAX);
        end else begin
            n_bon = i_div.quotient[BON_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_flags  <= '0;
            r_last   <= OVEN_IDLE;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_item  <= i_item;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_res_act  <= ACT_OFF;
                    r_res_mask <= '0;
                    r_res_bon  <= '0;
                    r_res_temp <= '0;
                    r_res_st   <= r_last;
                    r_is_start <= 1'b0;
                    case (r_item.opcode)
                        OP_START: begin
                            r_is_start <= 1'b1;
                            r_state    <= S_AVG;
                        end
                        OP_STOP: begin
                            r_flags[FL_ACTIVE]   <= 1'b0;
                            r_flags[FL_ATTEMP]   <= 1'b0;
                            r_flags[FL_OVERTEMP] <= 1'b0;
                            r_last     <= OVEN_IDLE;
                            r_res_st   <= OVEN_IDLE;
                            r_res_mask <= ALL_HEATERS;
                            r_state    <= S_FINISH;
                        end
                        OP_TICK: begin
                            if (!r_flags[FL_ACTIVE]) begin
                                r_state <= S_FINISH;
                            end else if (i_cfg.ramp_rate == '0 || n_sp >= n_target) begin
                                r_sp    <= r_item.target_temp;
                                r_state <= S_AVG;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_MUL: begin
                    r_div_go       <= 1'b1;
                    r_div_dividend <= DIV_W'(n_prod);
                    r_div_divisor  <= DVR_W'(MS_PER_S);
                    r_state        <= S_RAMP_WAIT;
                end
                S_RAMP_WAIT: begin
                    if (i_div.done) begin
                        r_sp    <= n_sp_next[SENSOR_W-1:0];
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (n_cnt == 2'd0) begin
                        if (r_is_start) begin
                            r_sp               <= '0;
                            r_flags[FL_ACTIVE] <= 1'b1;
                            r_last             <= OVEN_HEATING;
                            r_res_st           <= OVEN_HEATING;
                        end else begin
                            r_flags[FL_FAULT] <= 1'b1;
                            r_res_mask        <= i_cfg.heater_enable;
                        end
                        r_state <= S_FINISH;
                    end else begin
                        r_neg          <= n_sum[SUM_W-1];
                        r_div_go       <= 1'b1;
                        r_div_dividend <= DIV_W'(n_sum_mag);
                        r_div_divisor  <= DVR_W'(n_cnt);
                        r_state        <= S_AVG_WAIT;
                    end
                end
                S_AVG_WAIT: begin
                    if (i_div.done) begin
                        r_temp     <= n_avg[SENSOR_W-1:0];
                        r_res_temp <= n_avg[SENSOR_W-1:0];
                        if (r_is_start) begin
                            r_sp               <= n_avg[SENSOR_W-1:0];
                            r_flags[FL_ACTIVE] <= 1'b1;
                            r_last             <= OVEN_HEATING;
                            r_res_st           <= OVEN_HEATING;
                            r_state            <= S_FINISH;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_res_mask <= i_cfg.heater_enable;
                    r_state    <= S_FINISH;
                    if (n_temp >= n_limit) begin
                        r_flags[FL_OVERTEMP] <= 1'b1;
                        r_flags[FL_FAULT]    <= 1'b1;
                        r_last               <= OVEN_COOLING;
                        r_res_st             <= OVEN_COOLING;
                    end else if ((r_item.heater_fault & i_cfg.heater_enable) != '0) begin
                        r_flags[FL_FAULT] <= 1'b1;
                    end else begin
                        r_flags[FL_FAULT] <= 1'b0;
                        if (n_target < n_temp - n_tol) begin
                            r_flags[FL_ATTEMP] <= 1'b0;
                            r_last             <= OVEN_COOLING;
                            r_res_st           <= OVEN_COOLING;
                        end else if (n_temp < n_sp) begin
                            r_flags[FL_ATTEMP] <= 1'b0;
                            r_last             <= OVEN_HEATING;
                            r_res_st           <= OVEN_HEATING;
                            r_res_act          <= ACT_FULL;
                        end else begin
                            if (n_err <= n_tol) begin
                                r_flags[FL_ATTEMP] <= 1'b1;
                                r_last             <= OVEN_ATTEMP;
                                r_res_st           <= OVEN_ATTEMP;
                            end else begin
                                r_flags[FL_ATTEMP] <= 1'b0;
                                r_last             <= OVEN_HEATING;
                                r_res_st           <= OVEN_HEATING;
                            end
                            if (n_err_pos && i_cfg.tolerance != '0) begin
                                if (n_err >= n_tol) begin
                                    r_res_act <= ACT_FULL;
                                end else begin
                                    r_div_go       <= 1'b1;
                                    r_div_dividend <= n_pwr_dividend;
                                    r_div_divisor  <= i_cfg.tolerance;
                                    r_state        <= S_PWR_WAIT;
                                end
                            end
                        end
                    end
                end
                S_PWR_WAIT: begin
                    if (i_div.done) begin
                        if (i_div.quotient == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_div_go       <= 1'b1;
                            r_div_dividend <= n_burst_dividend;
                            r_div_divisor  <= DVR_W'(PWR_FULL_SCALE);
                            r_state        <= S_BURST_WAIT;
                        end
                    end
                end
                S_BURST_WAIT: begin
                    if (i_div.done) begin
                        r_res_act <= ACT_BURST;
                        r_res_bon <= n_bon;
                        r_state   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_cmd.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_div.go       = r_div_go;
    assign o_div.dividend = r_div_dividend;
    assign o_div.divisor  = r_div_divisor;

    assign o_sts.idle      = (r_state == S_IDLE);
    assign o_sts.res_valid = (r_state == S_FINISH);

    assign o_res.drive_action = r_res_act;
    assign o_res.drive_mask   = r_res_mask;
    assign o_res.burst_on     = r_res_bon;
    assign o_res.current_temp = r_res_temp;
    assign o_res.oven_state   = r_res_st;
    assign o_res.status_bits  = r_flags;

endmodule

>>> hdl/ramped_burst_fire_oven_regulator.sv
// Top level of the ramped burst-fire oven regulator: stream ports, configuration
// registers and output word register. Depends on rbfor_pkg, rbfor_ctrl and rbfor_div.
//
// One command word is taken at a time. A stop, a start with no fitted sensor and an
// ignored tick use no division; a start uses the shared divider once, for the sensor
// average, and a tick up to four times: for the ramp step, the sensor average, the
// proportional power and the burst-fire on-count. The input is ready again as soon
// as the result sits in the output register, so a new command is taken while that
// result still waits to be read.
`timescale 1ns / 1ps

module ramped_burst_fire_oven_regulator
    import rbfor_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Fields from bit 0: elapsed_ms, target_temp, temp_sensor_a, temp_sensor_b,
    // temp_sensor_c, sensor_fault, heater_fault, zero fill.
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // Fields from bit 0: drive_action, drive_mask, burst_on, current_temp,
    // oven_state, status_bits, zero fill.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_result   r_out;

    t_item     n_item;
    t_ctrl_cmd n_cmd;
    t_ctrl_sts w_sts;
    t_result   w_res;
    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;

    always_comb begin
        n_item.opcode        = t_opcode'(i_s_axis_tuser[1:0]);
        n_item.elapsed_ms    = i_s_axis_tdata[15:0];
        n_item.target_temp   = i_s_axis_tdata[35:16];
        n_item.temp_sensor_a = i_s_axis_tdata[55:36];
        n_item.temp_sensor_b = i_s_axis_tdata[75:56];
        n_item.temp_sensor_c = i_s_axis_tdata[95:76];
        n_item.sensor_fault  = i_s_axis_tdata[98:96];
        n_item.heater_fault  = i_s_axis_tdata[101:99];

        n_cmd.start = i_s_axis_tvalid && w_sts.idle;
        n_cmd.ack   = w_sts.res_valid && (!r_out_valid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_rate       <= RST_RAMP_RATE;
            r_cfg.tolerance       <= RST_TOLERANCE;
            r_cfg.heater_enable   <= RST_HEATER_EN;
            r_cfg.sensors_fitted  <= RST_SENSORS_FIT;
            r_cfg.over_temp_limit <= RST_OT_LIMIT;
            r_out_valid           <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RAMP_RATE:   r_cfg.ramp_rate       <= i_cfg_data[RATE_W-1:0];
                    CFG_TOLERANCE:   r_cfg.tolerance       <= i_cfg_data[TOL_W-1:0];
                    CFG_HEATER_EN:   r_cfg.heater_enable   <= i_cfg_data[MASK_W-1:0];
                    CFG_SENSORS_FIT: r_cfg.sensors_fitted  <= i_cfg_data[MASK_W-1:0];
                    CFG_OT_LIMIT:    r_cfg.over_temp_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (n_cmd.ack) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_cmd.ack) begin
            r_out <= w_res;
        end
    end

    rbfor_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (n_cmd),
        .i_item  (n_item),
        .i_div   (w_div_rsp),
        .o_div   (w_div_req),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    rbfor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_s_axis_tready = w_sts.idle;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.status_bits, r_out.oven_state,
                              r_out.current_temp, r_out.burst_on, r_out.drive_mask,
                              r_out.drive_action};
    assign o_cfg_ready     = 1'b1;

endmodule

>>> sim/tb.sv
// Self-checking testbench for ramped_burst_fire_oven_regulator: it drives commands, writes
// the registers between phases and checks every result word against its own prediction.
// Depends on rbfor_pkg and the regulator RTL.
`timescale 1ns / 1ps

module tb;
    import rbfor_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int T_MIN = -50000;
    localparam int T_MAX = 500000;

    class oven_drive_scoreboard;
        logic [RATE_W-1:0]  rate;
        logic [TOL_W-1:0]   tol;
        logic [MASK_W-1:0]  heat_en;
        logic [MASK_W-1:0]  fitted;
        logic [LIMIT_W-1:0] trip_limit;
        int                 setpoint;
        logic [3:0]         flags;
        t_oven_state        oven_st;
        t_result            drive_words_due[$];
        int                 mismatches;

        function new();
            rate       = RST_RAMP_RATE;
            tol        = RST_TOLERANCE;
            heat_en    = RST_HEATER_EN;
            fitted     = RST_SENSORS_FIT;
            trip_limit = RST_OT_LIMIT;
            setpoint   = 0;
            flags      = '0;
            oven_st    = OVEN_IDLE;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
            case (idx)
                CFG_RAMP_RATE:   rate       = value[RATE_W-1:0];
                CFG_TOLERANCE:   tol        = value[TOL_W-1:0];
                CFG_HEATER_EN:   heat_en    = value[MASK_W-1:0];
                CFG_SENSORS_FIT: fitted     = value[MASK_W-1:0];
                CFG_OT_LIMIT:    trip_limit = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return drive_words_due.size();
        endfunction

        // Works out the result word of one accepted command and updates the state.
        function void note_command(t_item c);
            t_result           r;
            int                s[3];
            int                sum;
            int                cnt;
            int                avg;
            int                target;
            logic [MASK_W-1:0] usable;
            longint            step;
            longint            rem;
            longint            err;
            longint            power;
            longint            n;
            r      = '0;
            s[0]   = c.temp_sensor_a;
            s[1]   = c.temp_sensor_b;
            s[2]   = c.temp_sensor_c;
            target = c.target_temp;
            sum    = 0;
            cnt    = 0;
            if (c.opcode == OP_START) begin
                for (int i = 0; i < 3; i++) begin
                    if (fitted[i]) begin
                        sum += s[i];
                        cnt++;
                    end
                end
                avg = (cnt > 0) ? sum / cnt : 0;
                setpoint = avg;
                flags[FL_ACTIVE] = 1'b1;
                oven_st = OVEN_HEATING;
                r.current_temp = avg[SENSOR_W-1:0];
            end else if (c.opcode == OP_STOP) begin
                flags[FL_ACTIVE]   = 1'b0;
                flags[FL_ATTEMP]   = 1'b0;
                flags[FL_OVERTEMP] = 1'b0;
                oven_st = OVEN_IDLE;
                r.drive_mask = ALL_HEATERS;
            end else if (c.opcode == OP_TICK && flags[FL_ACTIVE]) begin
                if (rate == 0 || setpoint >= target) begin
                    setpoint = target;
                end else begin
                    step = longint'(rate) * longint'(c.elapsed_ms) / MS_PER_S;
                    rem  = longint'(target) - longint'(setpoint);
                    setpoint = setpoint + int'((step < rem) ? step : rem);
                end
                usable = fitted & ~c.sensor_fault;
                for (int i = 0; i < 3; i++) begin
                    if (usable[i]) begin
                        sum += s[i];
                        cnt++;
                    end
                end
                r.drive_mask = heat_en;
                if (cnt == 0) begin
                    flags[FL_FAULT] = 1'b1;
                end else begin
                    avg = sum / cnt;
                    r.current_temp = avg[SENSOR_W-1:0];
                    if (longint'(avg) >= longint'(trip_limit)) begin
                        flags[FL_OVERTEMP] = 1'b1;
                        flags[FL_FAULT]    = 1'b1;
                        oven_st = OVEN_COOLING;
                    end else if ((c.heater_fault & heat_en) != '0) begin
                        flags[FL_FAULT] = 1'b1;
                    end else begin
                        flags[FL_FAULT] = 1'b0;
                        if (longint'(target) < longint'(avg) - longint'(tol)) begin
                            oven_st = OVEN_COOLING;
                            flags[FL_ATTEMP] = 1'b0;
                        end else if (avg < setpoint) begin
                            r.drive_action = ACT_FULL;
                            oven_st = OVEN_HEATING;
                            flags[FL_ATTEMP] = 1'b0;
                        end else begin
                            err = longint'(target) - longint'(avg);
                            power = (err > 0 && tol != 0) ?
                                    longint'(PWR_FULL_SCALE) * err / longint'(tol) : 0;
                            if (power >= PWR_FULL_SCALE) begin
                                r.drive_action = ACT_FULL;
                            end else if (power > 0) begin
                                n = (power * BURST_WINDOW + ROUND_HALF) / PWR_FULL_SCALE;
                                if (n == 0) n = 1;
                                if (n > BURST_MAX) n = BURST_MAX;
                                r.drive_action = ACT_BURST;
                                r.burst_on = n[BON_W-1:0];
                            end
                            if (err <= longint'(tol)) begin
                                oven_st = OVEN_ATTEMP;
                                flags[FL_ATTEMP] = 1'b1;
                            end else begin
                                oven_st = OVEN_HEATING;
                                flags[FL_ATTEMP] = 1'b0;
                            end
                        end
                    end
                end
            end
            r.oven_state  = oven_st;
            r.status_bits = flags;
            drive_words_due.push_back(r);
        endfunction

        function void report_field(string what, int want, int got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s differs, expected %0d, got %0d", $realtime, what,
                             want, got);
            end
        endfunction

        function void check_drive(logic [OUT_TDATA_W-1:0] word);
            t_result want;
            t_result got;
            got.drive_action = t_action'(word[1:0]);
            got.drive_mask   = word[4:2];
            got.burst_on     = word[9:5];
            got.current_temp = word[29:10];
            got.oven_state   = t_oven_state'(word[31:30]);
            got.status_bits  = word[35:32];
            if (drive_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word 0x%h arrived with none outstanding",
                             $realtime, word);
                return;
            end
            want = drive_words_due.pop_front();
            report_field("drive_action", int'(want.drive_action), int'(got.drive_action));
            report_field("drive_mask", int'(want.drive_mask), int'(got.drive_mask));
            report_field("burst_on", int'(want.burst_on), int'(got.burst_on));
            report_field("current_temp", int'(want.current_temp), int'(got.current_temp));
            report_field("oven_state", int'(want.oven_state), int'(got.oven_state));
            report_field("status_bits", int'(want.status_bits), int'(got.status_bits));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    oven_drive_scoreboard chk = new();
    int cycles = 0;
    int tx_n = 0;
    int rx_n = 0;
    int cur_tol = 5000;

    ramped_burst_fire_oven_regulator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_temp(int v);
        if (v < T_MIN) return T_MIN;
        if (v > T_MAX) return T_MAX;
        return v;
    endfunction

    function automatic t_item make_item(t_opcode op, int ms, int tgt, int a, int b, int c,
                                        int sf, int hf);
        t_item it;
        it.opcode        = op;
        it.elapsed_ms    = ms[MS_W-1:0];
        it.target_temp   = tgt[SENSOR_W-1:0];
        it.temp_sensor_a = a[SENSOR_W-1:0];
        it.temp_sensor_b = b[SENSOR_W-1:0];
        it.temp_sensor_c = c[SENSOR_W-1:0];
        it.sensor_fault  = sf[MASK_W-1:0];
        it.heater_fault  = hf[MASK_W-1:0];
        return it;
    endfunction

    task automatic send_command(t_item c);
        int gap;
        gap = ((tx_n / 64) % 4 == 1) ? 0 : int'($urandom_range(0, 5));
        tx_n++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, c.heater_fault, c.sensor_fault, c.temp_sensor_c,
                            c.temp_sensor_b, c.temp_sensor_a, c.target_temp, c.elapsed_ms};
        i_s_axis_tuser  <= c.opcode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        chk.note_command(c);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.set_register(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(int unsigned rate, int unsigned tol, int unsigned en,
                                 int unsigned fit, int unsigned limit);
        drain_results();
        write_reg(CFG_RAMP_RATE, rate);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_HEATER_EN, en);
        write_reg(CFG_SENSORS_FIT, fit);
        write_reg(CFG_OT_LIMIT, limit);
        cur_tol = int'(tol);
    endtask

    function automatic t_item make_tick(int target);
        int band;
        int base;
        int ms;
        band = (cur_tol > 2000) ? cur_tol : 2000;
        case ($urandom_range(0, 3))
            0: base = target - rand_between(0, 4 * band);
            1: base = target + rand_between(-band, band);
            2: base = target + rand_between(band, 4 * band);
            default: base = rand_between(T_MIN, T_MAX);
        endcase
        ms = ($urandom_range(0, 4) == 0) ? rand_between(0, 65535) : rand_between(0, 3000);
        return make_item(OP_TICK, ms, target,
                         clamp_temp(base + rand_between(-300, 300)),
                         clamp_temp(base + rand_between(-300, 300)),
                         clamp_temp(base + rand_between(-300, 300)),
                         ($urandom_range(0, 6) == 0) ? rand_between(0, 7) : 0,
                         ($urandom_range(0, 6) == 0) ? rand_between(0, 7) : 0);
    endfunction

    // Mostly start, a run of ticks and a stop, with stray commands in between.
    task automatic run_sessions(int count);
        int    sent;
        int    target;
        int    ambient;
        t_item c;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                c = make_item(t_opcode'($urandom_range(0, 2)), rand_between(0, 65535),
                              rand_between(T_MIN, T_MAX), rand_between(T_MIN, T_MAX),
                              rand_between(T_MIN, T_MAX), rand_between(T_MIN, T_MAX),
                              rand_between(0, 7), rand_between(0, 7));
                send_command(c);
                sent++;
            end else begin
                target  = rand_between(T_MIN, T_MAX);
                ambient = rand_between(T_MIN, 300000);
                send_command(make_item(OP_START, rand_between(0, 65535), target,
                                       clamp_temp(ambient + rand_between(-500, 500)),
                                       clamp_temp(ambient + rand_between(-500, 500)),
                                       clamp_temp(ambient + rand_between(-500, 500)),
                                       rand_between(0, 7), rand_between(0, 7)));
                sent++;
                repeat ($urandom_range(3, 30)) begin
                    if ($urandom_range(0, 9) == 0) target = rand_between(T_MIN, T_MAX);
                    send_command(make_tick(target));
                    sent++;
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_command(make_item(OP_STOP, 0, 0, 0, 0, 0, 0, 0));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = ((rx_n / 50) % 4 == 3) ? 0 : int'($urandom_range(0, 5));
            rx_n++;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            chk.check_drive(o_m_axis_tdata);
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Power-up settings: an ignored tick, then one short session.
        send_command(make_item(OP_TICK, 65535, T_MAX, T_MIN, T_MIN, T_MIN, 7, 7));
        send_command(make_item(OP_START, 0, 0, 20000, 22000, 24000, 0, 0));
        send_command(make_item(OP_TICK, 100, 100000, 20000, 20000, 20000, 0, 0));
        send_command(make_item(OP_STOP, 0, 0, 0, 0, 0, 0, 0));

        load_settings(10000, 5000, 7, 7, 280000);
        send_command(make_item(OP_START, 0, 0, 25000, 25000, 25000, 0, 0));
        send_command(make_item(OP_TICK, 0, 200000, 25000, 25000, 25000, 0, 0));
        send_command(make_item(OP_TICK, 1000, 200000, 25000, 25000, 25000, 0, 0));
        send_command(make_item(OP_TICK, 65535, 200000, 150000, 150000, 150000, 0, 0));
        send_command(make_item(OP_TICK, 10, 200000, 198000, 198000, 198000, 0, 0));
        send_command(make_item(OP_TICK, 10, 200000, 199990, 199990, 199990, 0, 0));
        send_command(make_item(OP_TICK, 10, 200000, 200000, 200000, 200000, 0, 0));
        send_command(make_item(OP_TICK, 10, 150000, 200000, 200000, 200000, 0, 0));
        send_command(make_item(OP_TICK, 10, 200000, 190000, 190000, 190000, 7, 0));
        send_command(make_item(OP_TICK, 10, 200000, T_MIN, T_MAX, 190000, 3, 0));
        send_command(make_item(OP_TICK, 10, 200000, 190000, 190000, 190000, 0, 2));
        send_command(make_item(OP_TICK, 10, 200000, 190000, 190000, 190000, 0, 0));
        send_command(make_item(OP_TICK, 10, T_MAX, 300000, 300000, 300000, 0, 0));
        send_command(make_item(OP_STOP, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_item(OP_START, 0, 0, T_MIN, T_MIN, T_MIN, 0, 0));
        send_command(make_item(OP_TICK, 500, T_MIN, T_MIN, T_MIN, T_MIN, 0, 0));
        send_command(make_item(OP_STOP, 0, 0, 0, 0, 0, 0, 0));

        load_settings(2000, 5000, 3, 0, 280000);
        send_command(make_item(OP_START, 0, 0, 100000, 100000, 100000, 0, 0));
        send_command(make_item(OP_TICK, 100, 200000, 100000, 100000, 100000, 0, 0));
        send_command(make_item(OP_STOP, 0, 0, 0, 0, 0, 0, 0));

        load_settings(100000, 50000, 7, 7, 500000);
        run_sessions(300);
        load_settings(0, 0, 5, 3, 0);
        run_sessions(150);
        load_settings(1, 1, 2, 4, 280000);
        run_sessions(150);
        repeat (4) begin
            load_settings($urandom_range(0, 100000), $urandom_range(0, 50000),
                          $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 500000));
            run_sessions(150);
        end
        load_settings(2000, 5000, 6, 0, 280000);
        run_sessions(50);

        drain_results();
        repeat (120) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
